FILE: src/sitda_pkg.sv
package sitda_pkg;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;

  // BCD layout: ten decimal digits cover any 32-bit magnitude
  localparam int DIGITS  = 10;
  localparam int DIGIT_W = 4;
  localparam int BCD_W   = DIGITS * DIGIT_W;
  localparam int CNT_W   = $clog2(VALUE_W + 1);
  localparam int LEFT_W  = $clog2(DIGITS + 1);

  // Character codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // Converter to emitter handoff
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic             neg;
  } sitda_conv_t;

  // Emitter sequencer states
  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SKIP,
    EM_EMIT
  } sitda_em_state_t;

endpackage

FILE: src/sitda_if.sv
interface sitda_in_if import sitda_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if import sitda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              is_last;

  modport source (output valid, output char_out, output is_last, input ready);
  modport sink   (input valid, input char_out, input is_last, output ready);
endinterface

FILE: src/sitda_conv.sv
// Bit-serial binary to BCD conversion (shift and add-3), one bit per cycle.
module sitda_conv import sitda_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      hand_valid,
  input  logic                      hand_ready,
  output sitda_conv_t               hand
);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] mag;
  logic [BCD_W-1:0]   bcd;
  logic               neg;
  logic [BCD_W-1:0]   bcd_adj;
  logic [VALUE_W-1:0] mag_in;
  logic               shift_done;

  assign shift_done = (cnt == CNT_W'(VALUE_W));
  assign in_ready   = !busy;
  assign hand_valid = busy && shift_done;
  assign hand.bcd   = bcd;
  assign hand.neg   = neg;

  // Magnitude fits 32 bits unsigned, the most negative value included
  assign mag_in = value[VALUE_W-1] ? (~value + 1'b1) : value;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && !shift_done) begin
      cnt <= cnt + 1'b1;
    end else if (hand_valid && hand_ready) begin
      busy <= 1'b0;
    end
  end

  // Shift path
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mag <= mag_in;
      bcd <= '0;
      neg <= value[VALUE_W-1];
    end else if (busy && !shift_done) begin
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
      mag <= {mag[VALUE_W-2:0], 1'b0};
    end
  end

endmodule

FILE: src/sitda_emit.sv
// Character sequencer: skips leading zero digits, then emits sign and digits.
module sitda_emit import sitda_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              hand_valid,
  output logic              hand_ready,
  input  sitda_conv_t       hand,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] char_out,
  output logic              is_last
);

  sitda_em_state_t     state, state_next;
  logic [BCD_W-1:0]    dig;
  logic [LEFT_W-1:0]   left;
  logic                neg_pend;
  logic [DIGIT_W-1:0]  top;
  logic                load;
  logic                shift;
  logic                clr_neg;

  assign top = dig[BCD_W-1 -: DIGIT_W];

  // Outputs come straight from held registers
  assign char_out = neg_pend ? ASCII_MINUS : (ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top});
  assign is_last  = !neg_pend && (left == LEFT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    hand_ready = 1'b0;
    out_valid  = 1'b0;
    load       = 1'b0;
    shift      = 1'b0;
    clr_neg    = 1'b0;
    unique case (state)
      EM_IDLE: begin
        hand_ready = 1'b1;
        if (hand_valid) begin
          load       = 1'b1;
          state_next = EM_SKIP;
        end
      end
      EM_SKIP: begin
        if (top == '0 && left != LEFT_W'(1)) begin
          shift = 1'b1;
        end else begin
          state_next = EM_EMIT;
        end
      end
      EM_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (neg_pend) begin
            clr_neg = 1'b1;
          end else if (left == LEFT_W'(1)) begin
            state_next = EM_IDLE;
          end else begin
            shift = 1'b1;
          end
        end
      end
      default: state_next = EM_IDLE;
    endcase
  end

  // Digit shift register
  always_ff @(posedge clk) begin
    if (load) begin
      dig      <= hand.bcd;
      left     <= LEFT_W'(DIGITS);
      neg_pend <= hand.neg;
    end else begin
      if (shift) begin
        dig  <= {dig[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        left <= left - 1'b1;
      end
      if (clr_neg) begin
        neg_pend <= 1'b0;
      end
    end
  end

endmodule

FILE: src/signed_int_to_decimal_ascii.sv
// Flow: the serial BCD shifter converts each accepted value in 32 shift steps and
// hands it to the emitter, which skips leading zero digits and then offers one
// character per cycle while out_ready is high (1 to 11 characters).
// The converter takes no new value until the emitter has taken its handoff;
// the next value converts while the previous one's characters are emitted.
// Reset (synchronous, rst high) idles both the converter and the emitter.
module signed_int_to_decimal_ascii import sitda_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sitda_in_if.sink     in_ch,
  sitda_out_if.source  out_ch
);

  logic        hand_valid;
  logic        hand_ready;
  sitda_conv_t hand;

  sitda_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .value      (in_ch.value),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .hand       (hand)
  );

  sitda_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .hand       (hand),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .char_out   (out_ch.char_out),
    .is_last    (out_ch.is_last)
  );

endmodule

FILE: src/sitda_checker.sv
module sitda_checker import sitda_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] char_out,
  input logic              is_last
);

  // Stalled character holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(is_last))
    else $error("stalled character changed");

  // Only sign or decimal digit codes
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> char_out == ASCII_MINUS ||
                  (char_out >= ASCII_ZERO && char_out <= ASCII_ZERO + 8'd9))
    else $error("bad character code");

  // A sign is always followed by digits
  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_out == ASCII_MINUS |-> !is_last)
    else $error("sign flagged last");

  // Characters of one number leave without gaps
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !is_last |=> out_valid)
    else $error("gap inside a number");

  // Nothing offered right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .char_out  (out_ch.char_out),
  .is_last   (out_ch.is_last)
);

FILE: test/tb_signed_int_to_decimal_ascii.sv
module tb_signed_int_to_decimal_ascii;
  import sitda_pkg::*;

  // One expected character of a number's text
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // One value waiting to be sent; hold_off makes the sender wait for a drain
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               hold_off;
  } pending_value_t;

  logic clk;
  logic rst;

  sitda_in_if  in_ch ();
  sitda_out_if out_ch ();

  signed_int_to_decimal_ascii u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pending_value_t pending_values[$];
  text_char_t     expected_text[$];
  int             errors    = 0;
  int             in_gap    = 0;
  int             in_calm   = 0;
  int             out_stall = 0;
  int             out_calm  = 0;
  logic           in_fired  = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Known input levels from time zero, then reset released at a falling edge
  initial begin
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Idle length: mostly none or short, a few long, with idle-free stretches
  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  // Decimal text of a signed value: optional minus, digits msd first
  task automatic push_decimal_text(input logic [VALUE_W-1:0] v);
    logic signed [VALUE_W:0] wide;
    logic [VALUE_W:0]        mag;
    longint unsigned         rest;
    logic [3:0]              digit[DIGITS];
    int                      ndig;
    text_char_t              c;
    wide = {v[VALUE_W-1], v};
    mag  = v[VALUE_W-1] ? -wide : wide;
    rest = 64'(mag);
    ndig = 0;
    do begin
      digit[ndig] = 4'(rest % 10);
      rest        = rest / 10;
      ndig++;
    end while (rest != 0 && ndig < DIGITS);
    if (v[VALUE_W-1]) begin
      c.ch   = ASCII_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      c.ch   = ASCII_ZERO + CHAR_W'(digit[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endtask

  // Random value: a mix of plain random, small, round, zero-heavy and edge values
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    longint             acc;
    int                 n;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 999);
      2: begin
        acc = 1;
        n   = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) acc = acc * 10;
        acc = acc + $urandom_range(0, 2) - 1;
        v   = acc[VALUE_W-1:0];
      end
      3: begin
        // digits with many interior zeros
        acc = 0;
        n   = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          acc = acc * 10 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 9));
        end
        if (acc > 64'sd2147483647) acc = acc % 64'sd2147483648;
        v = acc[VALUE_W-1:0];
      end
      4: v = ($urandom_range(0, 1) == 0) ? 32'h7fff_ffff - $urandom_range(0, 20)
                                         : 32'h8000_0000 + $urandom_range(0, 20);
      default: v = $urandom() >> $urandom_range(0, 31);
    endcase
    if (($urandom_range(0, 1) == 0) && v != 32'h8000_0000) v = -v;
    return v;
  endfunction

  task automatic queue_value(input logic [VALUE_W-1:0] v, input logic hold);
    pending_value_t p;
    p.value    = v;
    p.hold_off = hold;
    pending_values.push_back(p);
  endtask

  // Input driver: present queued values at the falling edge
  always @(negedge clk) begin
    logic [VALUE_W-1:0] nxt_value;
    logic               nxt_valid;
    pending_value_t     p;
    nxt_value = in_ch.value;
    nxt_valid = in_ch.valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      nxt_valid = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (pending_values.size() != 0 &&
                   !(pending_values[0].hold_off && expected_text.size() != 0)) begin
        p         = pending_values.pop_front();
        nxt_value = p.value;
        nxt_valid = 1'b1;
        in_gap    = draw_gap(in_calm);
      end
    end
    if (in_fired) in_fired <= 1'b0;
    in_ch.valid <= nxt_valid;
    in_ch.value <= nxt_value;
  end

  // Output side: ready with random stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall != 0) begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall = draw_gap(out_calm);
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    text_char_t e;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        push_decimal_text(in_ch.value);
        in_fired <= 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected char %0d last %0b",
                                    out_ch.char_out, out_ch.is_last));
        end else begin
          e = expected_text.pop_front();
          if (out_ch.char_out !== e.ch)
            report_mismatch($sformatf("char_out %0d, want %0d", out_ch.char_out, e.ch));
          if (out_ch.is_last !== e.last)
            report_mismatch($sformatf("is_last %0b, want %0b (char %0d)",
                                      out_ch.is_last, e.last, e.ch));
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int waited;
    // directed: zero, extremes, round numbers, interior zeros
    queue_value(32'd0, 1'b0);
    queue_value(32'd1, 1'b0);
    queue_value(-32'sd1, 1'b0);
    queue_value(32'd9, 1'b0);
    queue_value(32'd10, 1'b0);
    queue_value(-32'sd10, 1'b0);
    queue_value(32'd105, 1'b0);
    queue_value(-32'sd105, 1'b0);
    queue_value(32'd100, 1'b0);
    queue_value(32'd1000000007, 1'b0);
    queue_value(32'd1000000000, 1'b0);
    queue_value(-32'sd1000000000, 1'b0);
    queue_value(32'd999999999, 1'b0);
    queue_value(32'h7fff_ffff, 1'b0);
    queue_value(32'h8000_0000, 1'b0);
    queue_value(32'h8000_0001, 1'b1);
    queue_value(32'h8000_0000, 1'b0);
    queue_value(32'd2000000002, 1'b0);
    queue_value(-32'sd2000000002, 1'b0);
    queue_value(32'hffff_fffe, 1'b0);
    // random part
    for (int i = 0; i < 260; i++) begin
      queue_value(pick_value(), (i == 0) || ($urandom_range(0, 99) < 3));
    end

    @(negedge rst);
    while (pending_values.size() != 0 || in_ch.valid) @(posedge clk);
    waited = 0;
    while (expected_text.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (expected_text.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
    if (errors == 0) begin
      $display("[signed_int_to_decimal_ascii] OK");
    end else begin
      $display("[signed_int_to_decimal_ascii] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 1500000);
    $display("[signed_int_to_decimal_ascii] ERROR");
    $finish;
  end

endmodule

FILE: files.f
src/sitda_pkg.sv
src/sitda_if.sv
src/sitda_conv.sv
src/sitda_emit.sv
src/signed_int_to_decimal_ascii.sv
src/sitda_checker.sv
test/tb_signed_int_to_decimal_ascii.sv
